// ===== src/pitch_run_segmenter_macros.svh =====
// assertion macros for the pitch run segmenter
`ifndef PITCH_RUN_SEGMENTER_MACROS_SVH
`define PITCH_RUN_SEGMENTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("prs assertion failed");

// next-cycle implication, disabled during reset
`define PRS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("prs assertion failed");

`endif

// ===== src/prs_pkg.sv =====
// shared types, constants and the median function of the pitch run segmenter
package prs_pkg;

    localparam int HZ_W        = 20;
    localparam int TOL_W       = 16;
    localparam int CNT_W       = 17;
    localparam int FRAME_W     = 16;
    localparam int TOTAL_W     = 36;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 72;
    localparam int STEP_W      = $clog2(HZ_W + 1);

    localparam logic [TOL_W-1:0]   TOL_RESET  = 16'd517;
    localparam logic [FRAME_W-1:0] FRAME_LAST = {FRAME_W{1'b1}};

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FEED_S = 6'b000010,
        ST_FEED_X = 6'b000100,
        ST_FINAL  = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_PUSH   = 6'b100000
    } prs_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]   run_length;
        logic [FRAME_W-1:0] start_frame;
        logic [FRAME_W-1:0] end_frame;
        logic               final_run;
        logic               last_result;
    } prs_job_t;

    function automatic logic [HZ_W-1:0] median3(input logic [HZ_W-1:0] a,
                                                input logic [HZ_W-1:0] b,
                                                input logic [HZ_W-1:0] c);
        logic [HZ_W-1:0] m;
        if ((b >= a && b <= c) || (b <= a && b >= c)) begin
            m = b;
        end else if ((c >= a && c <= b) || (c <= a && c >= b)) begin
            m = c;
        end else begin
            m = a;
        end
        return m;
    endfunction

endpackage

// ===== src/pitch_run_segmenter.sv =====
// top level of the pitch run segmenter: median smoothing, run control and result sequencing
// a frame that closes no run is taken in ST_IDLE and, past the first frame, smoothed in ST_FEED_S
// each emitted run passes ST_DIV, waiting on the bit-serial divider, and ST_PUSH, which loads the output
// a last frame also passes ST_FEED_X (past the first frame) and ST_FINAL; ST_PUSH waits on m_tready
// reset: aresetn synchronous active low, tolerance back to 517, stream state cleared
// the result register is emptied on reset, and a new frame is taken while a result waits
module pitch_run_segmenter import prs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [TOL_W-1:0]       cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // peak_hz [19:0], zero [23:20]
    input  logic                   s_tlast,   // last_frame
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // run_length, mean_hz, start_frame, end_frame, zero
    output logic                   m_tlast,   // final_run
    output logic                   m_tuser    // last_result
);

`include "pitch_run_segmenter_macros.svh"

    prs_state_t         state_reg, state_next;
    prs_state_t         ret_reg, ret_next;
    logic [TOL_W-1:0]   tol_reg, tol_next;
    logic [HZ_W-1:0]    x_reg, x_next;
    logic               last_reg, last_next;
    logic [HZ_W-1:0]    prev_reg, prev_next;
    logic [HZ_W-1:0]    pend_reg, pend_next;
    logic               have_reg, have_next;
    logic [FRAME_W-1:0] fidx_reg, fidx_next;
    logic [HZ_W-1:0]    ref_reg, ref_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [FRAME_W-1:0] first_reg, first_next;
    prs_job_t           job_reg, job_next;

    logic               div_start;
    logic               div_busy;
    logic [HZ_W-1:0]    div_quo;
    logic               out_load;

    logic [HZ_W-1:0]    s_val;
    logic [HZ_W-1:0]    fv;
    logic               in_band;
    logic               term;
    logic [HZ_W-1:0]    in_hz;

    assign in_hz    = s_tdata[HZ_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_val    = (fidx_reg == FRAME_W'(1)) ? pend_reg : median3(prev_reg, pend_reg, x_reg);
    assign fv       = (state_reg == ST_FEED_X) ? x_reg : s_val;
    assign in_band  = ({1'b0, fv} < ({1'b0, ref_reg} + (HZ_W+1)'(tol_reg))) &&
                      (({1'b0, fv} + (HZ_W+1)'(tol_reg)) > {1'b0, ref_reg});
    assign term     = last_reg || (fidx_reg == FRAME_LAST);

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        tol_next   = cfg_we ? cfg_wdata : tol_reg;
        x_next     = x_reg;
        last_next  = last_reg;
        prev_next  = prev_reg;
        pend_next  = pend_reg;
        have_next  = have_reg;
        fidx_next  = fidx_reg;
        ref_next   = ref_reg;
        total_next = total_reg;
        count_next = count_reg;
        first_next = first_reg;
        job_next   = job_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next    = in_hz;
                    last_next = s_tlast;
                    if (!have_reg) begin
                        if (s_tlast) begin
                            ref_next   = in_hz;
                            total_next = TOTAL_W'(in_hz);
                            count_next = CNT_W'(1);
                            first_next = '0;
                            state_next = ST_FINAL;
                        end else begin
                            pend_next = in_hz;
                            have_next = 1'b1;
                            fidx_next = FRAME_W'(1);
                        end
                    end else begin
                        state_next = ST_FEED_S;
                    end
                end
            end
            ST_FEED_S: begin
                if (!term) begin
                    prev_next = s_val;
                    pend_next = x_reg;
                    fidx_next = fidx_reg + 1'b1;
                end
                if (fidx_reg == FRAME_W'(1)) begin
                    ref_next   = s_val;
                    total_next = TOTAL_W'(s_val);
                    count_next = CNT_W'(1);
                    first_next = '0;
                    state_next = term ? ST_FEED_X : ST_IDLE;
                end else if (in_band) begin
                    count_next = count_reg + 1'b1;
                    total_next = total_reg + TOTAL_W'(s_val);
                    state_next = term ? ST_FEED_X : ST_IDLE;
                end else begin
                    job_next.run_length  = count_reg;
                    job_next.start_frame = first_reg;
                    job_next.end_frame   = fidx_reg - FRAME_W'(2);
                    job_next.final_run   = 1'b0;
                    job_next.last_result = ~term;
                    div_start  = 1'b1;
                    ref_next   = s_val;
                    total_next = TOTAL_W'(s_val);
                    count_next = CNT_W'(1);
                    first_next = fidx_reg - 1'b1;
                    ret_next   = term ? ST_FEED_X : ST_IDLE;
                    state_next = ST_DIV;
                end
            end
            ST_FEED_X: begin
                if (in_band) begin
                    count_next = count_reg + 1'b1;
                    total_next = total_reg + TOTAL_W'(x_reg);
                    state_next = ST_FINAL;
                end else begin
                    job_next.run_length  = count_reg;
                    job_next.start_frame = first_reg;
                    job_next.end_frame   = fidx_reg - 1'b1;
                    job_next.final_run   = 1'b0;
                    job_next.last_result = 1'b0;
                    div_start  = 1'b1;
                    ref_next   = x_reg;
                    total_next = TOTAL_W'(x_reg);
                    count_next = CNT_W'(1);
                    first_next = fidx_reg;
                    ret_next   = ST_FINAL;
                    state_next = ST_DIV;
                end
            end
            ST_FINAL: begin
                job_next.run_length  = count_reg;
                job_next.start_frame = first_reg;
                job_next.end_frame   = fidx_reg;
                job_next.final_run   = 1'b1;
                job_next.last_result = 1'b1;
                div_start  = 1'b1;
                prev_next  = '0;
                pend_next  = '0;
                have_next  = 1'b0;
                fidx_next  = '0;
                ref_next   = '0;
                total_next = '0;
                count_next = '0;
                first_next = '0;
                ret_next   = ST_IDLE;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!m_tvalid || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ret_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            tol_reg   <= TOL_RESET;
            prev_reg  <= '0;
            pend_reg  <= '0;
            have_reg  <= 1'b0;
            fidx_reg  <= '0;
            ref_reg   <= '0;
            total_reg <= '0;
            count_reg <= '0;
            first_reg <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            tol_reg   <= tol_next;
            prev_reg  <= prev_next;
            pend_reg  <= pend_next;
            have_reg  <= have_next;
            fidx_reg  <= fidx_next;
            ref_reg   <= ref_next;
            total_reg <= total_next;
            count_reg <= count_next;
            first_reg <= first_next;
        end
        x_reg    <= x_next;
        last_reg <= last_next;
        job_reg  <= job_next;
    end

    prs_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    prs_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .job      (job_reg),
        .mean_hz  (div_quo),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // open stream past its first frame always holds a run
    `PRS_ASSERT_IMP(a_run_nonempty, aclk, aresetn, have_reg && (fidx_reg >= FRAME_W'(2)), count_reg != '0)
    // mean is only taken once the divider has finished
    `PRS_ASSERT_IMP(a_load_div_done, aclk, aresetn, out_load, !div_busy)
    // the final run of a stream ends the work on that frame
    `PRS_ASSERT_NXT(a_final_to_idle, aclk, aresetn, out_load && job_reg.final_run, state_reg == ST_IDLE)

endmodule

// ===== src/prs_divider.sv =====
// bit-serial restoring divider for the run mean, one quotient bit per cycle
module prs_divider import prs_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [TOTAL_W-1:0]  dividend,
    input  logic [CNT_W-1:0]    divisor,
    output logic                busy,
    output logic [HZ_W-1:0]     quotient
);

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [HZ_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    trial;

    assign shifted = {rem_reg, quo_reg[HZ_W-1]};
    assign trial   = shifted - {1'b0, div_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = {{(CNT_W-(TOTAL_W-HZ_W)){1'b0}}, dividend[TOTAL_W-1:HZ_W]};
            quo_next  = dividend[HZ_W-1:0];
            div_next  = divisor;
            step_next = STEP_W'(HZ_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[CNT_W]) begin
                rem_next = trial[CNT_W-1:0];
            end else begin
                rem_next = shifted[CNT_W-1:0];
            end
            quo_next  = {quo_reg[HZ_W-2:0], ~trial[CNT_W]};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/prs_out_stage.sv =====
// output register of the result stream
module prs_out_stage import prs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  prs_job_t               job,
    input  logic [HZ_W-1:0]        mean_hz,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    logic                   valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg;
    logic                   last_reg;
    logic                   user_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            data_reg <= {3'b000, job.end_frame, job.start_frame, mean_hz, job.run_length};
            last_reg <= job.final_run;
            user_reg <= job.last_result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule
